### src/fasc_pkg.sv
// ---------------------------------------------------------------------------
// fasc_pkg
// Types and constants shared by the span cache hit check files.
// ---------------------------------------------------------------------------
package fasc_pkg;

    localparam int ADDR_W     = 10;
    localparam int LINE_IDX_W = 6;
    localparam int CNT_W      = 32;
    localparam int BLOCK_SPAN = 8;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [LINE_IDX_W-1:0] t_line_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef struct packed {
        logic      hit;
        t_line_idx idx;
    } t_match;

endpackage

### src/fasc_if.sv
// ---------------------------------------------------------------------------
// fasc_req_if / fasc_rsp_if
// Valid/ready channels for request addresses and lookup results.
// ---------------------------------------------------------------------------
interface fasc_req_if;
    import fasc_pkg::*;

    logic  valid;
    logic  ready;
    t_addr address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface fasc_rsp_if;
    import fasc_pkg::*;

    logic      valid;
    logic      ready;
    logic      hit;
    t_line_idx line_index;
    t_cnt      hit_total;
    t_cnt      access_total;

    modport source (output valid, output hit, output line_index, output hit_total,
                    output access_total, input ready);
    modport sink   (input valid, input hit, input line_index, input hit_total,
                    input access_total, output ready);
endinterface

### src/fasc_match.sv
// ---------------------------------------------------------------------------
// fasc_match
// Parallel span compare of one address against every line base, lowest
// covering line wins.
// ---------------------------------------------------------------------------
module fasc_match #(
    parameter int LINES = 10
) (
    input  fasc_pkg::t_addr  i_addr,
    input  fasc_pkg::t_addr  i_base [LINES],
    output fasc_pkg::t_match o_match
);
    import fasc_pkg::*;

    logic [LINES-1:0]  covered;
    logic [ADDR_W:0]   diff [LINES];

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            diff[i]    = {1'b0, i_addr} - {1'b0, i_base[i]};
            covered[i] = !diff[i][ADDR_W] && (diff[i] < (ADDR_W+1)'(BLOCK_SPAN));
        end
    end

    always_comb begin
        o_match.hit = |covered;
        o_match.idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (covered[i]) begin
                o_match.idx = LINE_IDX_W'(i);
            end
        end
    end

endmodule

### src/fifo_assoc_span_cache_hit_check.sv
// ---------------------------------------------------------------------------
// fifo_assoc_span_cache_hit_check
// Fully associative span lookup with round-robin line replacement and
// saturating hit and access counts.
// Stages: input register, compare, result register. The result register
// loads an item once it is empty or the receiver is taking its content.
// Throughput: one item per cycle while o_rsp.ready stays high.
// Reset (sync, active low): all line bases, victim pointer and counters to
// zero, so the first BLOCK_SPAN addresses hit from reset.
// ---------------------------------------------------------------------------
module fifo_assoc_span_cache_hit_check #(
    parameter int LINES = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fasc_req_if.sink   i_req,
    fasc_rsp_if.source o_rsp
);
    import fasc_pkg::*;

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    logic             r_s1_vld;
    t_addr            r_s1_addr;
    t_addr            r_base [LINES];
    logic [IDX_W-1:0] r_victim;
    logic [IDX_W-1:0] n_victim;
    t_cnt             r_hit_cnt;
    t_cnt             n_hit_cnt;
    t_cnt             r_acc_cnt;
    t_cnt             n_acc_cnt;

    logic             r_out_vld;
    logic             r_out_hit;
    t_line_idx        r_out_idx;
    t_cnt             r_out_hit_tot;
    t_cnt             r_out_acc_tot;

    t_match           match;
    logic             out_free;
    logic             s1_adv;

    fasc_match #(.LINES(LINES)) u_match (
        .i_addr  (r_s1_addr),
        .i_base  (r_base),
        .o_match (match)
    );

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign s1_adv      = r_s1_vld && out_free;
    assign i_req.ready = !r_s1_vld || out_free;

    always_comb begin
        n_victim  = (r_victim == IDX_W'(LINES - 1)) ? '0 : r_victim + 1'b1;
        n_hit_cnt = (match.hit && (r_hit_cnt != '1)) ? r_hit_cnt + 1'b1 : r_hit_cnt;
        n_acc_cnt = (r_acc_cnt != '1) ? r_acc_cnt + 1'b1 : r_acc_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_vld <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_s1_addr <= i_req.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                r_base[i] <= '0;
            end
            r_victim  <= '0;
            r_hit_cnt <= '0;
            r_acc_cnt <= '0;
        end else if (s1_adv) begin
            if (!match.hit) begin
                r_base[r_victim] <= r_s1_addr;
                r_victim         <= n_victim;
            end
            r_hit_cnt <= n_hit_cnt;
            r_acc_cnt <= n_acc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
        if (s1_adv) begin
            r_out_hit     <= match.hit;
            r_out_idx     <= match.hit ? match.idx : LINE_IDX_W'(r_victim);
            r_out_hit_tot <= n_hit_cnt;
            r_out_acc_tot <= n_acc_cnt;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.line_index   = r_out_idx;
    assign o_rsp.hit_total    = r_out_hit_tot;
    assign o_rsp.access_total = r_out_acc_tot;

    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_victim <= IDX_W'(LINES - 1))
        else $error("victim pointer out of range");

    a_hits_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_hit_tot <= r_out_acc_tot))
        else $error("hit total exceeds access total");

    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (r_acc_cnt != '1) |=> (r_acc_cnt == $past(r_acc_cnt) + 1'b1))
        else $error("access count did not advance");

    a_miss_moves_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && !match.hit |=> (r_victim != $past(r_victim)) || (LINES == 1))
        else $error("miss did not advance victim pointer");

endmodule

### dv/fifo_assoc_span_cache_hit_check_tb.sv
// ---------------------------------------------------------------------------
// fifo_assoc_span_cache_hit_check_tb
// Drives request addresses into the span cache lookup and checks every
// result item against a local model of the line bases, the round-robin
// victim pointer and the saturating counts. A directed table comes first:
// reset hits, overlapping lines and spans at the top of memory. Random
// items follow, mostly drawn from a small moving working set. Both sides
// idle at random. There is one long receiver hold-off and one drain pause.
// ---------------------------------------------------------------------------
module fifo_assoc_span_cache_hit_check_tb;
    import fasc_pkg::*;

    localparam int LINES        = 10;
    localparam int RAND_ITEMS   = 500;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_ITEM    = 80;
    localparam int DRAIN_ITEM   = 150;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 320;

    typedef struct packed {
        logic      hit;
        t_line_idx idx;
        t_cnt      hits;
        t_cnt      accesses;
    } t_lookup;

    typedef struct {
        t_addr   addr;
        bit      typed;
        t_lookup res;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fasc_req_if req_if ();
    fasc_rsp_if rsp_if ();

    fifo_assoc_span_cache_hit_check #(
        .LINES(LINES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // local copy of the cache state
    t_addr     model_base [LINES];
    t_line_idx model_victim;
    t_cnt      model_hits;
    t_cnt      model_accesses;

    t_lookup   lookups_due [$];
    t_stim_row stim_table [$];
    int        mismatches = 0;
    int        cycles     = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;
    logic      hold_req   = 1'b0;
    logic      calm       = 1'b0;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_lookup lookup_span(input t_addr a);
        t_lookup   r;
        int        v;
        bit        found;
        t_line_idx line;
        found = 1'b0;
        line  = '0;
        for (int i = 0; i < LINES; i++) begin
            if (!found && int'(a) >= int'(model_base[i]) &&
                int'(a) - int'(model_base[i]) < BLOCK_SPAN) begin
                found = 1'b1;
                line  = t_line_idx'(i);
            end
        end
        if (found) begin
            model_hits = sat_inc(model_hits);
        end else begin
            v = int'(model_victim);
            if (v >= LINES) v = 0;
            model_base[v] = a;
            line = t_line_idx'(v);
            v = v + 1;
            if (v >= LINES) v = 0;
            model_victim = t_line_idx'(v);
        end
        model_accesses = sat_inc(model_accesses);
        r.hit      = found;
        r.idx      = line;
        r.hits     = model_hits;
        r.accesses = model_accesses;
        return r;
    endfunction

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    task automatic add_row(input t_addr a, input bit typed, input logic hit,
                           input int idx, input int hits, input int accesses);
        t_stim_row row;
        row.addr         = a;
        row.typed        = typed;
        row.res.hit      = hit;
        row.res.idx      = t_line_idx'(idx);
        row.res.hits     = t_cnt'(hits);
        row.res.accesses = t_cnt'(accesses);
        stim_table.push_back(row);
    endtask

    task automatic pause_sender(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_addr(input t_addr a, input bit typed, input t_lookup want);
        t_lookup p;
        req_if.valid   <= 1'b1;
        req_if.address <= a;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        p = lookup_span(a);
        lookups_due.push_back(typed ? want : p);
    endtask

    task automatic check_result();
        t_lookup e;
        if (lookups_due.size() == 0) begin
            report("result item with nothing expected");
            return;
        end
        e = lookups_due.pop_front();
        if (rsp_if.hit !== e.hit)
            report($sformatf("hit %b, expected %b", rsp_if.hit, e.hit));
        if (rsp_if.line_index !== e.idx)
            report($sformatf("line_index %0d, expected %0d", rsp_if.line_index, e.idx));
        if (rsp_if.hit_total !== e.hits)
            report($sformatf("hit_total %0d, expected %0d", rsp_if.hit_total, e.hits));
        if (rsp_if.access_total !== e.accesses)
            report($sformatf("access_total %0d, expected %0d",
                             rsp_if.access_total, e.accesses));
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check, then choose next ready
    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    initial begin
        t_addr     pool [POOL_SIZE];
        t_addr     a;
        t_lookup   none;
        int        r;
        none = '0;
        req_if.valid   = 1'b0;
        req_if.address = '0;
        rsp_if.ready   = 1'b1;
        for (int i = 0; i < LINES; i++) model_base[i] = '0;
        model_victim   = '0;
        model_hits     = '0;
        model_accesses = '0;
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = t_addr'($urandom);

        // all bases zero from reset; overlaps; spans at the top of memory
        add_row(10'd0,    1'b1, 1'b1, 0, 1, 1);
        add_row(10'd7,    1'b1, 1'b1, 0, 2, 2);
        add_row(10'd8,    1'b1, 1'b0, 0, 2, 3);
        add_row(10'd0,    1'b1, 1'b1, 1, 3, 4);
        add_row(10'd1023, 1'b1, 1'b0, 1, 3, 5);
        add_row(10'd1020, 1'b1, 1'b0, 2, 3, 6);
        add_row(10'd1023, 1'b1, 1'b1, 1, 4, 7);
        add_row(10'd1022, 1'b0, 1'b0, 0, 0, 0);
        add_row(10'd15,   1'b0, 1'b0, 0, 0, 0);
        add_row(10'd16,   1'b0, 1'b0, 0, 0, 0);
        add_row(10'd9,    1'b0, 1'b0, 0, 0, 0);
        add_row(10'd19,   1'b0, 1'b0, 0, 0, 0);
        add_row(10'd13,   1'b0, 1'b0, 0, 0, 0);
        add_row(10'h155,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'h2AA,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'h200,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'h1FF,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'd1016, 1'b0, 1'b0, 0, 0, 0);
        add_row(10'd1019, 1'b0, 1'b0, 0, 0, 0);
        add_row(10'd4,    1'b0, 1'b0, 0, 0, 0);
        add_row(10'd1,    1'b0, 1'b0, 0, 0, 0);
        add_row(10'h3F8,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'h203,  1'b0, 1'b0, 0, 0, 0);
        add_row(10'd2,    1'b0, 1'b0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            if ($urandom_range(99) < 9) pause_sender($urandom_range(1, 4));
            send_addr(stim_table[k].addr, stim_table[k].typed, stim_table[k].res);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_ITEM) hold_req <= 1'b1;
            if (n == CALM_FIRST) calm <= 1'b1;
            if (n == CALM_LAST) calm <= 1'b0;
            if (n == DRAIN_ITEM) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                while (lookups_due.size() != 0) @(posedge i_clk);
            end else if ((n < CALM_FIRST || n >= CALM_LAST) && $urandom_range(99) < 9) begin
                pause_sender($urandom_range(1, 4));
            end
            r = $urandom_range(99);
            if (r < 60)
                a = pool[$urandom_range(POOL_SIZE - 1)] + t_addr'($urandom_range(9));
            else if (r < 85)
                a = t_addr'($urandom);
            else if (r < 93)
                a = t_addr'(1023 - $urandom_range(15));
            else
                a = t_addr'($urandom_range(15));
            if ($urandom_range(19) == 0) pool[$urandom_range(POOL_SIZE - 1)] = t_addr'($urandom);
            send_addr(a, 1'b0, none);
        end

        req_if.valid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### fifo_assoc_span_cache_hit_check.f
src/fasc_pkg.sv
src/fasc_if.sv
src/fasc_match.sv
src/fifo_assoc_span_cache_hit_check.sv
dv/fifo_assoc_span_cache_hit_check_tb.sv
